>>> hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion wrappers: implication under reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

>>> hw/rtl/swv_pkg.sv
`timescale 1ns / 1ps
package swv_pkg;
  localparam int unsigned RingDepth = 1024;
  localparam int unsigned RingAw = $clog2(RingDepth);
  localparam int unsigned FillW = RingAw + 1;
  localparam int unsigned TimeW = 44;
  localparam int unsigned PriceW = 32;
  localparam int unsigned QtyW = 22;
  localparam int unsigned WinW = 27;
  localparam int unsigned SumW = 64;
  localparam int unsigned EntryW = TimeW + PriceW + QtyW;
  localparam logic [WinW-1:0] WindowReset = 27'd300000;
  localparam logic OpTrade = 1'b0;

  typedef struct packed {
    logic              op;
    logic [TimeW-1:0]  time_ms;
    logic [PriceW-1:0] price;
    logic [QtyW-1:0]   qty;
    logic              sell_side;
  } in_item_t;

  typedef struct packed {
    logic [PriceW-1:0] last_price;
    logic [QtyW-1:0]   last_qty;
    logic              last_sell;
    logic [31:0]       session_vwap;
    logic [31:0]       window_vwap;
    logic [10:0]       window_count;
    logic              overflow_flag;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_DROP_RD, ST_DROP_WAIT, ST_DROP_SUB, ST_WRITE,
    ST_EV_RD, ST_EV_WAIT, ST_EV_CHK, ST_EV_SUB, ST_DIV_S, ST_DIV_W, ST_OUT
  } state_e;

  typedef struct packed {
    logic        start;
    logic [SumW-1:0] num;
    logic [SumW-1:0] den;
  } div_req_t;
endpackage

>>> hw/rtl/swv_in_if.sv
`timescale 1ns / 1ps
interface swv_in_if import swv_pkg::*;;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/swv_out_if.sv
`timescale 1ns / 1ps
interface swv_out_if import swv_pkg::*;;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/swv_cfg_if.sv
`timescale 1ns / 1ps
interface swv_cfg_if import swv_pkg::*;;
  logic            valid;
  logic            ready;
  logic [WinW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/swv_ram.sv
`timescale 1ns / 1ps
module swv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> hw/rtl/swv_div.sv
`timescale 1ns / 1ps
module swv_div import swv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [SumW-1:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [SumW:0]   trial;
  logic [SumW:0]   shifted;

  always_comb begin
    rem_d   = rem_q;
    quo_d   = quo_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q, quo_q[SumW-1]};
    trial   = shifted - {1'b0, den_q};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.num;
      den_d  = req_i.den;
      cnt_d  = 7'd0;
      busy_d = (req_i.den != '0);
      done_d = (req_i.den == '0);
    end else if (busy_q) begin
      if (!trial[SumW]) begin
        rem_d = trial[SumW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b1};
      end else begin
        rem_d = shifted[SumW-1:0];
        quo_d = {quo_q[SumW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'(SumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = (den_q == '0) ? 32'd0 :
                  (quo_q[SumW-1:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];
endmodule

>>> hw/rtl/session_and_window_vwap_unit.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_ch    in   op, time_ms, price, qty, sell_side
// out_ch   out  last trade, session/window VWAP, window_count, overflow_flag
// cfg_ch   in   window_ms
// One item at a time, trade or time-only. A full ring drops its oldest entry
// before a trade is written, and each expired entry is then evicted in turn;
// two 64-step divisions run through one shared restoring divider, and a
// division by a zero quantity sum skips its steps.
// Reset clears sums, ring pointers and window_ms to 300000; ring storage is
// left unwritten. A stalled result holds the block until it transfers.
`include "assert_macros.svh"
module session_and_window_vwap_unit import swv_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  swv_in_if.sink    in_ch,
  swv_out_if.source out_ch,
  swv_cfg_if.sink   cfg_ch
);
  state_e state_q, state_d;
  in_item_t item_q;
  logic [WinW-1:0]   win_q;
  logic [PriceW-1:0] lp_q;
  logic [QtyW-1:0]   lq_q;
  logic              ls_q;
  logic [SumW-1:0]   sv_q, sq_q, wv_q, wq_q, prod_q, sub_q;
  logic [RingAw-1:0] head_q;
  logic [FillW-1:0]  fill_q;
  logic              ovf_q;
  logic [31:0]       svw_q;
  logic              div_go_q;
  logic              ram_we;
  logic [RingAw-1:0] ram_wa;
  logic [EntryW-1:0] ram_rd;
  div_req_t          dreq;
  logic              ddone;
  logic [31:0]       dquot;
  logic [TimeW-1:0]  e_time;
  logic [PriceW-1:0] e_price;
  logic [QtyW-1:0]   e_qty;
  logic [TimeW:0]    lim;
  logic              full;
  logic [PriceW-1:0] mul_a;
  logic [QtyW-1:0]   mul_b;
  logic [PriceW+QtyW-1:0] mul_p;

  assign {e_time, e_price, e_qty} = ram_rd;
  assign full = (fill_q == FillW'(RingDepth));
  assign lim  = {1'b0, e_time} + {{(TimeW-WinW+1){1'b0}}, win_q};
  assign ram_wa = RingAw'(head_q + fill_q[RingAw-1:0]);
  assign mul_a = (state_q == ST_MUL) ? item_q.price : e_price;
  assign mul_b = (state_q == ST_MUL) ? item_q.qty : e_qty;
  assign mul_p = mul_a * mul_b;

  swv_ram #(.Width(EntryW), .Depth(RingDepth)) u_ring (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa),
    .wdata_i({item_q.time_ms, item_q.price, item_q.qty}),
    .raddr_i(head_q), .rdata_o(ram_rd)
  );

  swv_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:      if (in_ch.valid) state_d = (in_ch.data.op == OpTrade) ? ST_MUL : ST_EV_RD;
      ST_MUL:       state_d = ST_ADD;
      ST_ADD:       state_d = full ? ST_DROP_RD : ST_WRITE;
      ST_DROP_RD:   state_d = ST_DROP_WAIT;
      ST_DROP_WAIT: state_d = ST_DROP_SUB;
      ST_DROP_SUB:  state_d = ST_WRITE;
      ST_WRITE:     state_d = ST_EV_RD;
      ST_EV_RD:     state_d = (fill_q == '0) ? ST_DIV_S : ST_EV_WAIT;
      ST_EV_WAIT:   state_d = ST_EV_CHK;
      ST_EV_CHK:    state_d = (lim < {1'b0, item_q.time_ms}) ? ST_EV_SUB : ST_DIV_S;
      ST_EV_SUB:    state_d = ST_EV_RD;
      ST_DIV_S:     if (ddone) state_d = ST_DIV_W;
      ST_DIV_W:     if (ddone) state_d = ST_OUT;
      ST_OUT:       if (out_ch.ready) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready  = (state_q == ST_IDLE);
    cfg_ch.ready = (state_q == ST_IDLE);
    out_ch.valid = (state_q == ST_OUT);
    ram_we       = (state_q == ST_WRITE);
    dreq.start   = div_go_q;
    dreq.num     = (state_q == ST_DIV_W) ? wv_q : sv_q;
    dreq.den     = (state_q == ST_DIV_W) ? wq_q : sq_q;
    out_ch.data  = '{last_price: lp_q, last_qty: lq_q, last_sell: ls_q,
                     session_vwap: svw_q, window_vwap: dquot,
                     window_count: 11'(fill_q), overflow_flag: ovf_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      win_q    <= WindowReset;
      lp_q <= '0; lq_q <= '0; ls_q <= 1'b0;
      sv_q <= '0; sq_q <= '0; wv_q <= '0; wq_q <= '0;
      head_q <= '0; fill_q <= '0; ovf_q <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      div_go_q <= (state_q == ST_EV_RD && fill_q == '0) ||
                  (state_q == ST_EV_CHK && state_d == ST_DIV_S) ||
                  (state_q == ST_DIV_S && ddone);
      if (cfg_ch.valid && cfg_ch.ready) win_q <= cfg_ch.data;
      case (state_q)
        ST_ADD: begin
          lp_q <= item_q.price; lq_q <= item_q.qty; ls_q <= item_q.sell_side;
          ovf_q <= ovf_q | (sv_q > ~prod_q) | (sq_q > ~SumW'(item_q.qty));
          if (sv_q > ~prod_q) begin
            sv_q <= '1;
          end else sv_q <= sv_q + prod_q;
          if (sq_q > ~SumW'(item_q.qty)) begin
            sq_q <= '1;
          end else sq_q <= sq_q + SumW'(item_q.qty);
          wv_q <= wv_q + prod_q;
          wq_q <= wq_q + SumW'(item_q.qty);
        end
        ST_DROP_WAIT: sub_q <= SumW'(mul_p);
        ST_DROP_SUB: begin
          wv_q <= wv_q - sub_q; wq_q <= wq_q - SumW'(e_qty);
          head_q <= head_q + 1'b1; fill_q <= fill_q - 1'b1; ovf_q <= 1'b1;
        end
        ST_WRITE: fill_q <= fill_q + 1'b1;
        ST_EV_CHK: sub_q <= SumW'(mul_p);
        ST_EV_SUB: begin
          wv_q <= wv_q - sub_q; wq_q <= wq_q - SumW'(e_qty);
          head_q <= head_q + 1'b1; fill_q <= fill_q - 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
    if (state_q == ST_MUL) prod_q <= SumW'(mul_p);
    if (state_q == ST_DIV_S && ddone) svw_q <= dquot;
  end

  `ASSERT_IMPL(a_fill_max, clk_i, rst_ni, 1'b1, fill_q <= FillW'(RingDepth))
  `ASSERT_IMPL(a_busy_no_ready, clk_i, rst_ni, state_q != ST_IDLE, !in_ch.ready)
  `ASSERT_NEXT(a_write_grows, clk_i, rst_ni, state_q == ST_WRITE, fill_q == $past(fill_q) + 1'b1)
endmodule

>>> sim/tb_session_and_window_vwap_unit.sv
`timescale 1ns / 1ps
module tb_session_and_window_vwap_unit import swv_pkg::*;;

  localparam logic OpTimeOnly = 1'b1;
  localparam int unsigned StallMax = 17;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned HoldOffCycles = 3000;
  localparam longint unsigned CycleLimit = 3000000;
  localparam logic [SumW-1:0] SumMax = '1;

  class vwap_scoreboard;
    logic [WinW-1:0]   window_len;
    logic [PriceW-1:0] last_px;
    logic [QtyW-1:0]   last_lots;
    logic              last_side;
    logic [SumW-1:0]   sess_value, sess_lots, win_value, win_lots;
    logic [TimeW-1:0]  trade_time [RingDepth];
    logic [PriceW-1:0] trade_px [RingDepth];
    logic [QtyW-1:0]   trade_lots [RingDepth];
    int unsigned       head, fill;
    logic              sticky;
    out_item_t         expected_q[$];
    int unsigned       mismatches;
    int unsigned       results_seen;

    function new();
      window_len = WindowReset;
      last_px = '0;
      last_lots = '0;
      last_side = 1'b0;
      sess_value = '0;
      sess_lots = '0;
      win_value = '0;
      win_lots = '0;
      head = 0;
      fill = 0;
      sticky = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function logic [SumW-1:0] sat_sum(logic [SumW-1:0] a, logic [SumW-1:0] b);
      if (a > SumMax - b) begin
        sticky = 1'b1;
        return SumMax;
      end
      return a + b;
    endfunction

    function logic [31:0] vwap(logic [SumW-1:0] num, logic [SumW-1:0] den);
      logic [SumW-1:0] q;
      if (den == '0) return '0;
      q = num / den;
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function void evict_oldest();
      win_value -= SumW'(trade_px[head]) * SumW'(trade_lots[head]);
      win_lots -= SumW'(trade_lots[head]);
      head = (head + 1) % RingDepth;
      fill--;
    endfunction

    function void note_input(in_item_t it);
      logic [SumW-1:0] value;
      int unsigned tail;
      out_item_t e;
      if (it.op == OpTrade) begin
        value = SumW'(it.price) * SumW'(it.qty);
        last_px = it.price;
        last_lots = it.qty;
        last_side = it.sell_side;
        sess_value = sat_sum(sess_value, value);
        sess_lots = sat_sum(sess_lots, SumW'(it.qty));
        if (fill >= RingDepth) begin
          evict_oldest();
          sticky = 1'b1;
        end
        tail = (head + fill) % RingDepth;
        trade_time[tail] = it.time_ms;
        trade_px[tail] = it.price;
        trade_lots[tail] = it.qty;
        fill++;
        win_value += value;
        win_lots += SumW'(it.qty);
      end
      while (fill > 0 &&
             SumW'(trade_time[head]) + SumW'(window_len) < SumW'(it.time_ms))
        evict_oldest();
      e.last_price = last_px;
      e.last_qty = last_lots;
      e.last_sell = last_side;
      e.session_vwap = vwap(sess_value, sess_lots);
      e.window_vwap = vwap(win_value, win_lots);
      e.window_count = 11'(fill);
      e.overflow_flag = sticky;
      expected_q.insert(expected_q.size(), e);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = expected_q[0];
      expected_q.delete(0);
      if (got.last_price !== e.last_price || got.last_qty !== e.last_qty ||
          got.last_sell !== e.last_sell || got.session_vwap !== e.session_vwap ||
          got.window_vwap !== e.window_vwap || got.window_count !== e.window_count ||
          got.overflow_flag !== e.overflow_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch\n  exp %p\n  got %p", results_seen, e, got);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  swv_in_if  in_ch ();
  swv_out_if out_ch ();
  swv_cfg_if cfg_ch ();

  session_and_window_vwap_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  vwap_scoreboard vwap_sb = new();
  logic idling_on = 1'b1;
  logic [TimeW-1:0] now_ms = '0;
  longint unsigned cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    vwap_sb.note_input(it);
    if (idling_on && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, StallMax)) @(posedge clk_i);
    end
  endtask

  task automatic write_window(logic [WinW-1:0] len);
    in_ch.valid <= 1'b0;
    while (vwap_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= len;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    vwap_sb.window_len = len;
  endtask

  function automatic in_item_t make_item(int unsigned max_pct, int unsigned step,
                                         int unsigned back_pct, int unsigned tonly_pct);
    in_item_t it;
    if ($urandom_range(99) < back_pct)
      now_ms = now_ms - TimeW'($urandom_range(step));
    else
      now_ms = now_ms + TimeW'($urandom_range(step));
    it.op = ($urandom_range(99) < tonly_pct) ? OpTimeOnly : OpTrade;
    it.time_ms = now_ms;
    it.sell_side = 1'($urandom_range(1));
    if ($urandom_range(99) < max_pct) begin
      it.price = '1;
      it.qty = '1;
    end else begin
      it.price = $urandom;
      it.qty = QtyW'($urandom);
      if ($urandom_range(3) == 0) it.price = $urandom_range(1000);
      if ($urandom_range(3) == 0) it.qty = QtyW'($urandom_range(20));
    end
    return it;
  endfunction

  function automatic in_item_t item_of(logic op, logic [TimeW-1:0] t, logic [PriceW-1:0] px,
                                       logic [QtyW-1:0] q, logic side);
    in_item_t it;
    it.op = op;
    it.time_ms = t;
    it.price = px;
    it.qty = q;
    it.sell_side = side;
    return it;
  endfunction

  initial begin
    bit held_off;
    int unsigned stall;
    held_off = 1'b0;
    stall = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) vwap_sb.check_result(out_ch.data);
      if (!held_off && vwap_sb.results_seen == 200) begin
        held_off = 1'b1;
        stall = HoldOffCycles;
      end
      if (stall > 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(7) == 0) begin
        stall = $urandom_range(1, StallMax) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(item_of(OpTimeOnly, 44'd0, '1, '1, 1'b1));
    send_item(item_of(OpTrade, 44'd0, '1, '1, 1'b1));
    send_item(item_of(OpTrade, 44'd10, '0, 22'd5, 1'b0));
    send_item(item_of(OpTrade, 44'd20, 32'd12345, '0, 1'b1));
    send_item(item_of(OpTrade, 44'd300000, 32'd1, 22'd1, 1'b0));
    send_item(item_of(OpTimeOnly, 44'd300010, 32'd77, 22'd3, 1'b0));
    send_item(item_of(OpTimeOnly, 44'd300021, '0, '0, 1'b0));
    send_item(item_of(OpTrade, 44'd5, 32'd999, 22'd7, 1'b1));
    send_item(item_of(OpTimeOnly, 44'd600001, '0, '0, 1'b0));
    send_item(item_of(OpTrade, 44'd600002, 32'hAAAA_AAAA, 22'h15_5555, 1'b1));
    send_item(item_of(OpTimeOnly, '1, '1, '1, 1'b1));
    send_item(item_of(OpTrade, '1, 32'h5555_5555, 22'h2A_AAAA, 1'b0));

    now_ms = 44'd1000;
    write_window(27'd86400000);
    repeat (450) send_item(make_item(90, 1000, 0, 5));

    write_window(27'd1000);
    repeat (150) send_item(make_item(5, 400, 10, 25));

    write_window(27'd0);
    repeat (60) send_item(make_item(5, 3, 20, 20));

    now_ms = 44'hFFF_F000_0000;
    write_window('1);
    repeat (60) send_item(make_item(5, 32'h0100_0000, 5, 20));

    now_ms = 44'd0;
    write_window(27'd1);
    idling_on = 1'b0;
    repeat (70) send_item(make_item(5, 3, 10, 25));
    in_ch.valid <= 1'b0;

    while (vwap_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (vwap_sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/swv_pkg.sv
hw/rtl/swv_in_if.sv
hw/rtl/swv_out_if.sv
hw/rtl/swv_cfg_if.sv
hw/rtl/swv_ram.sv
hw/rtl/swv_div.sv
hw/rtl/session_and_window_vwap_unit.sv
sim/tb_session_and_window_vwap_unit.sv
